FILE: rtl/core/hpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants for the binary min-heap priority queue: entry
// layout, status codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int PRI_W   = 16;
  localparam int DAT_W   = 32;
  localparam int COUNT_W = 7;

  // One heap entry: priority and its data word.
  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [DAT_W-1:0] dat;
  } entry_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_CMP,
    S_DEL_ROOT,
    S_DEL_LAST,
    S_DEL_TAKE,
    S_DN_CHK,
    S_DN_RIGHT,
    S_DN_CMP,
    S_RESP
  } state_t;

  // Which heap position the read port addresses.
  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  // Which entry is written at the current position.
  typedef enum logic [1:0] {
    WR_NEW,
    WR_PARENT,
    WR_LAST,
    WR_CHILD
  } wr_sel_t;

  // How the current position moves.
  typedef enum logic [1:0] {
    POS_HOLD,
    POS_PARENT,
    POS_CHILD
  } pos_step_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    pos_step_t pos_step;
    logic      latch_root;
    logic      latch_last;
    logic      latch_left;
    logic      set_status;
    status_t   status;
    logic      count_inc;
    logic      count_dec;
    logic      res_load;
  } ctrl_t;

  // Conditions reported by the datapath to the controller.
  typedef struct packed {
    logic is_del;
    logic full;
    logic empty;
    logic at_root;
    logic left_ok;
    logic right_ok;
    logic new_less;
    logic last_le_child;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/binary_min_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_unit
// Min-heap priority queue of up to CAPACITY entries. Each input transaction
// inserts an entry or removes the smallest-priority one and returns one
// result transaction with the removed entry, a status code and the count.
//
//   Channel  Direction  Payload
//   s_axis   in         tuser: cmd; tdata: in_priority, in_data
//   m_axis   out        tuser: status; tdata: out_data, out_priority,
//                       is_empty, entry_count
//
// An insert sifts its new entry up and a delete sifts the last entry down, one heap
// level at a time and at most log2(CAPACITY) levels, through the single memory read
// port: a sift-down level fetches the left child and, if present, the right child.
// A delete first fetches the root and the last entry; a rejection does no sifting.
// One item is worked on at a time; a new item is taken while a result still waits
// in the output register. rst is synchronous and empties the queue; memory
// contents are not cleared.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_unit
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] in_priority, [47:16] in_data
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] out_data, [47:32] out_priority,
                                      // [48] is_empty, [55:49] entry_count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  ctrl_t              ctrl;
  dp_stat_t           stat;
  logic [DAT_W-1:0]   res_dat;
  logic [PRI_W-1:0]   res_pri;
  status_t            res_status;
  logic               res_empty;
  logic [COUNT_W-1:0] res_count;

  // Sequencer.
  hpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Heap storage and arithmetic.
  hpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_del     (s_axis_tuser[0]),
    .in_pri     (s_axis_tdata[15:0]),
    .in_dat     (s_axis_tdata[47:16]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_dat    (res_dat),
    .out_pri    (res_pri),
    .out_status (res_status),
    .out_empty  (res_empty),
    .out_count  (res_count)
  );

  // Result packing.
  assign m_axis_tdata = {res_count, res_empty, res_pri, res_dat};
  assign m_axis_tuser = res_status;

endmodule

FILE: rtl/core/hpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_ctrl
// Sequencer for the heap queue: steps an insert through its sift-up levels and
// a delete through root fetch and sift-down levels, then hands off the result.
// ----------------------------------------------------------------------------
module hpq_ctrl
  import hpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctrl_t    ctrl
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    ctrl          = '0;
    ctrl.rd_sel   = RD_ROOT;
    ctrl.wr_sel   = WR_NEW;
    ctrl.pos_step = POS_HOLD;
    ctrl.status   = ST_OK;
    in_ready      = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_DISPATCH;
        end
      end

      // Reject or start the operation.
      S_DISPATCH: begin
        if (stat.is_del) begin
          if (stat.empty) begin
            ctrl.set_status = 1'b1;
            ctrl.status     = ST_EMPTY;
            state_next      = S_RESP;
          end else begin
            state_next = S_DEL_ROOT;
          end
        end else begin
          if (stat.full) begin
            ctrl.set_status = 1'b1;
            ctrl.status     = ST_FULL;
            state_next      = S_RESP;
          end else begin
            state_next = S_INS_CHK;
          end
        end
      end

      // Sift up: fetch the parent unless the root is reached.
      S_INS_CHK: begin
        if (stat.at_root) begin
          ctrl.wr_en     = 1'b1;
          ctrl.wr_sel    = WR_NEW;
          ctrl.count_inc = 1'b1;
          state_next     = S_RESP;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = RD_PARENT;
          state_next  = S_INS_CMP;
        end
      end

      // Move the parent down or place the new entry.
      S_INS_CMP: begin
        ctrl.wr_en = 1'b1;
        if (stat.new_less) begin
          ctrl.wr_sel   = WR_PARENT;
          ctrl.pos_step = POS_PARENT;
          state_next    = S_INS_CHK;
        end else begin
          ctrl.wr_sel    = WR_NEW;
          ctrl.count_inc = 1'b1;
          state_next     = S_RESP;
        end
      end

      S_DEL_ROOT: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_sel = RD_ROOT;
        state_next  = S_DEL_LAST;
      end

      S_DEL_LAST: begin
        ctrl.latch_root = 1'b1;
        ctrl.rd_en      = 1'b1;
        ctrl.rd_sel     = RD_LAST;
        state_next      = S_DEL_TAKE;
      end

      S_DEL_TAKE: begin
        ctrl.latch_last = 1'b1;
        state_next      = S_DN_CHK;
      end

      // Sift down: fetch the left child if there is one.
      S_DN_CHK: begin
        if (!stat.left_ok) begin
          ctrl.wr_en     = 1'b1;
          ctrl.wr_sel    = WR_LAST;
          ctrl.count_dec = 1'b1;
          state_next     = S_RESP;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = RD_LEFT;
          state_next  = S_DN_RIGHT;
        end
      end

      S_DN_RIGHT: begin
        ctrl.latch_left = 1'b1;
        if (stat.right_ok) begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = RD_RIGHT;
        end
        state_next = S_DN_CMP;
      end

      // Stop at the smaller child or pull it up one level.
      S_DN_CMP: begin
        ctrl.wr_en = 1'b1;
        if (stat.last_le_child) begin
          ctrl.wr_sel    = WR_LAST;
          ctrl.count_dec = 1'b1;
          state_next     = S_RESP;
        end else begin
          ctrl.wr_sel   = WR_CHILD;
          ctrl.pos_step = POS_CHILD;
          state_next    = S_DN_CHK;
        end
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (stat.out_free) begin
          ctrl.res_load = 1'b1;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/hpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_dp
// Heap datapath: entry memory with one write and one registered read port,
// position and count registers, operand latches and the result register.
// ----------------------------------------------------------------------------
module hpq_dp
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  output dp_stat_t           stat,
  input  logic               in_del,
  input  logic [PRI_W-1:0]   in_pri,
  input  logic [DAT_W-1:0]   in_dat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DAT_W-1:0]   out_dat,
  output logic [PRI_W-1:0]   out_pri,
  output status_t            out_status,
  output logic               out_empty,
  output logic [COUNT_W-1:0] out_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  entry_t mem [CAPACITY];

  logic               cmd_del;
  entry_t             new_ent;
  entry_t             last_ent;
  entry_t             left_ent;
  entry_t             rd_ent;
  entry_t             res_ent;
  status_t            res_status;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   count;

  logic [CNT_W:0]     left_pos;
  logic [CNT_W:0]     right_pos;
  logic [CNT_W:0]     count_ext;
  logic [CNT_W:0]     rd_pos;
  logic [CNT_W:0]     rd_off;
  logic [CNT_W:0]     wr_off;
  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic               right_smaller;
  entry_t             child_ent;
  logic [CNT_W-1:0]   child_pos;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  // Child positions and the count on a common width.
  assign left_pos  = {pos, 1'b0};
  assign right_pos = {pos, 1'b1};
  assign count_ext = {1'b0, count};

  // The right child wins only when strictly smaller; ties go left.
  assign right_smaller = stat.right_ok && (left_ent.pri > rd_ent.pri);
  assign child_ent     = right_smaller ? rd_ent : left_ent;
  assign child_pos     = right_smaller ? right_pos[CNT_W-1:0] : left_pos[CNT_W-1:0];

  // Status toward the controller.
  always_comb begin
    stat.is_del        = cmd_del;
    stat.full          = (count == CNT_W'(CAPACITY));
    stat.empty         = (count == '0);
    stat.at_root       = (pos == CNT_W'(1));
    stat.left_ok       = (left_pos <= count_ext);
    stat.right_ok      = (right_pos <= count_ext);
    stat.new_less      = (new_ent.pri < rd_ent.pri);
    stat.last_le_child = (last_ent.pri <= child_ent.pri);
    stat.out_free      = !out_valid || out_ready;
  end

  // Read address: heap positions are one-based, memory indexes zero-based.
  always_comb begin
    unique case (ctrl.rd_sel)
      RD_ROOT:   rd_pos = (CNT_W + 1)'(1);
      RD_LAST:   rd_pos = count_ext;
      RD_PARENT: rd_pos = {2'b00, pos[CNT_W-1:1]};
      RD_LEFT:   rd_pos = left_pos;
      RD_RIGHT:  rd_pos = right_pos;
      default:   rd_pos = (CNT_W + 1)'(1);
    endcase
  end

  assign rd_off = rd_pos - (CNT_W + 1)'(1);
  assign raddr  = rd_off[IDX_W-1:0];
  assign wr_off = {1'b0, pos} - (CNT_W + 1)'(1);
  assign waddr  = wr_off[IDX_W-1:0];

  // Write data selection.
  always_comb begin
    unique case (ctrl.wr_sel)
      WR_NEW:    wdata = new_ent;
      WR_PARENT: wdata = rd_ent;
      WR_LAST:   wdata = last_ent;
      WR_CHILD:  wdata = child_ent;
      default:   wdata = new_ent;
    endcase
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.rd_en) begin
      rd_ent <= mem[raddr];
    end
  end

  // Operand latches and result payload.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_del     <= in_del;
      new_ent.pri <= in_pri;
      new_ent.dat <= in_dat;
      res_ent     <= '0;
      res_status  <= ST_OK;
    end
    if (ctrl.latch_root) begin
      res_ent <= rd_ent;
    end
    if (ctrl.latch_last) begin
      last_ent <= rd_ent;
    end
    if (ctrl.latch_left) begin
      left_ent <= rd_ent;
    end
    if (ctrl.set_status) begin
      res_status <= ctrl.status;
    end
  end

  // Current heap position.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pos <= in_del ? CNT_W'(1) : count + CNT_W'(1);
    end else begin
      unique case (ctrl.pos_step)
        POS_HOLD:   pos <= pos;
        POS_PARENT: pos <= {1'b0, pos[CNT_W-1:1]};
        POS_CHILD:  pos <= child_pos;
        default:    pos <= pos;
      endcase
    end
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.count_inc) begin
      count <= count + CNT_W'(1);
    end else if (ctrl.count_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  assign count_wide = {{COUNT_W{1'b0}}, count};

  // Output register, one transaction deep.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      out_dat    <= res_ent.dat;
      out_pri    <= res_ent.pri;
      out_status <= res_status;
      out_empty  <= (count == '0);
      out_count  <= count_wide[COUNT_W-1:0];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("heap count exceeds capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
    ((count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1))))
    else $error("heap count moved by more than one");

  a_empty_reject: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_empty && (out_count == '0)))
    else $error("empty rejection reported with entries held");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (ctrl.wr_en && ctrl.rd_en) |-> (waddr != raddr))
    else $error("read and write hit the same entry in one cycle");

  a_pos_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_en |-> ((pos != '0) && (pos <= CNT_W'(CAPACITY))))
    else $error("write outside the heap");
`endif

endmodule
